// ===== sv/tes_pkg.sv =====
// ----------------------------------------------------------------------------
// tes_pkg
// Shared constants, codes and control structs of the timer expiry scheduler.
// ----------------------------------------------------------------------------
package tes_pkg;

    localparam int NUM_TIMERS = 16;
    localparam int MAX_FIRES  = 64;

    localparam int SLOT_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int ID_W   = 4;
    localparam int IVL_W  = 31;
    localparam int TIME_W = 32;
    localparam int CNT_W  = 5;
    localparam int FIRE_W = $clog2(MAX_FIRES + 1);

    typedef enum logic [1:0] {
        CMD_INSERT  = 2'd0,
        CMD_RESTART = 2'd1,
        CMD_REMOVE  = 2'd2,
        CMD_TICK    = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_APPLY,
        ST_REPLY,
        ST_SCAN,
        ST_DECIDE,
        ST_FIRE
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic apply;
        logic scan_step;
        logic fire;
    } dp_ctl_t;

    // datapath -> controller
    typedef struct packed {
        logic is_tick;
        logic scan_last;
        logic found;
        logic have_prev;
        logic fires_left;
    } dp_stat_t;

    // controller -> output register
    typedef struct packed {
        logic emit;
        logic fired;
        logic last;
    } out_ctl_t;

endpackage

// ===== sv/tes_datapath.sv =====
// ----------------------------------------------------------------------------
// tes_datapath
// Slot store, serial earliest-deadline scan, saturating adder, active count.
// ----------------------------------------------------------------------------
module tes_datapath
    import tes_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  dp_ctl_t           ctl,
    input  logic [1:0]        command,
    input  logic [ID_W-1:0]   timer_id,
    input  logic [IVL_W-1:0]  interval,
    input  logic              mode,
    input  logic [TIME_W-1:0] now,
    output dp_stat_t          stat,
    output logic [SLOT_W-1:0] fired_slot,
    output logic [CNT_W-1:0]  pending_count
);

    // latched input item
    cmd_t              cmd_reg;
    logic [ID_W-1:0]   id_reg;
    logic [IVL_W-1:0]  ivl_reg;
    logic              mode_reg;
    logic [TIME_W-1:0] now_reg;

    // slot store
    logic [NUM_TIMERS-1:0] active_reg;
    logic [NUM_TIMERS-1:0] periodic_reg;
    logic [IVL_W-1:0]      interval_reg [NUM_TIMERS];
    logic [TIME_W-1:0]     deadline_reg [NUM_TIMERS];
    logic [CNT_W-1:0]      count_reg;

    // scan state
    logic [SLOT_W-1:0] idx_reg;
    logic [SLOT_W-1:0] best_id_reg;
    logic [TIME_W-1:0] best_dl_reg;
    logic              found_reg;
    logic [SLOT_W-1:0] fired_id_reg;
    logic [FIRE_W-1:0] n_reg;

    logic              id_ok;
    logic [SLOT_W-1:0] slot;
    logic [SLOT_W-1:0] rd_idx;
    logic [IVL_W-1:0]  ivl_eff;
    logic [TIME_W-1:0] add_a;
    logic [IVL_W-1:0]  add_b;
    logic [TIME_W:0]   sum;
    logic [TIME_W-1:0] sat_sum;
    logic [TIME_W-1:0] cur_dl;
    logic              eligible;
    logic              better;

    assign id_ok   = 32'(id_reg) < NUM_TIMERS;
    assign slot    = id_reg[SLOT_W-1:0];
    assign ivl_eff = (ivl_reg == '0) ? IVL_W'(1) : ivl_reg;

    // one adder shared by insert/restart (now + interval) and periodic re-arm
    assign rd_idx  = ctl.fire ? best_id_reg : slot;
    assign add_a   = ctl.fire ? best_dl_reg : now_reg;
    assign add_b   = (!ctl.fire && cmd_reg == CMD_INSERT) ? ivl_eff : interval_reg[rd_idx];
    assign sum     = {1'b0, add_a} + {2'b00, add_b};
    assign sat_sum = sum[TIME_W] ? '1 : sum[TIME_W-1:0];

    // one slot examined per cycle; strict compare keeps the lower slot on a tie
    assign cur_dl   = deadline_reg[idx_reg];
    assign eligible = active_reg[idx_reg] && (cur_dl <= now_reg);
    assign better   = eligible && (!found_reg || cur_dl < best_dl_reg);

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg  <= cmd_t'(command);
            id_reg   <= timer_id;
            ivl_reg  <= interval;
            mode_reg <= mode;
            now_reg  <= now;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg   <= '0;
            periodic_reg <= '0;
            count_reg    <= '0;
        end
        else if (ctl.apply && id_ok)
        begin
            unique case (cmd_reg)
                CMD_INSERT:
                begin
                    active_reg[slot]   <= 1'b1;
                    periodic_reg[slot] <= mode_reg;
                    if (!active_reg[slot])
                        count_reg <= count_reg + CNT_W'(1);
                end
                CMD_REMOVE:
                begin
                    active_reg[slot] <= 1'b0;
                    if (active_reg[slot])
                        count_reg <= count_reg - CNT_W'(1);
                end
                default: ;
            endcase
        end
        else if (ctl.fire && !periodic_reg[best_id_reg])
        begin
            active_reg[best_id_reg] <= 1'b0;
            count_reg               <= count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.apply && id_ok)
        begin
            if (cmd_reg == CMD_INSERT)
            begin
                interval_reg[slot] <= ivl_eff;
                deadline_reg[slot] <= sat_sum;
            end
            else if (cmd_reg == CMD_RESTART && active_reg[slot])
                deadline_reg[slot] <= sat_sum;
        end
        else if (ctl.fire && periodic_reg[best_id_reg])
            deadline_reg[best_id_reg] <= sat_sum;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            found_reg <= 1'b0;
            n_reg     <= '0;
        end
        else if (ctl.load)
        begin
            idx_reg   <= '0;
            found_reg <= 1'b0;
            n_reg     <= '0;
        end
        else if (ctl.fire)
        begin
            idx_reg   <= '0;
            found_reg <= 1'b0;
            n_reg     <= n_reg + FIRE_W'(1);
        end
        else if (ctl.scan_step)
        begin
            idx_reg <= idx_reg + SLOT_W'(1);
            if (better)
                found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.scan_step && better)
        begin
            best_id_reg <= idx_reg;
            best_dl_reg <= cur_dl;
        end
        if (ctl.fire)
            fired_id_reg <= best_id_reg;
    end

    assign stat.is_tick    = (cmd_reg == CMD_TICK);
    assign stat.scan_last  = (idx_reg == SLOT_W'(NUM_TIMERS - 1));
    assign stat.found      = found_reg;
    assign stat.have_prev  = (n_reg != '0);
    assign stat.fires_left = (n_reg < FIRE_W'(MAX_FIRES));

    assign fired_slot    = fired_id_reg;
    assign pending_count = count_reg;

    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) == $countones(active_reg))
        else $error("active count out of step with active flags");

    a_fire_needs_find: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.fire |-> found_reg && active_reg[best_id_reg] && n_reg < FIRE_W'(MAX_FIRES))
        else $error("fire without an eligible slot or past the fire limit");

    a_fire_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(n_reg) <= MAX_FIRES)
        else $error("fire count beyond limit");

endmodule

// ===== sv/tes_ctrl.sv =====
// ----------------------------------------------------------------------------
// tes_ctrl
// Sequencer: command apply, scan/fire loop and result issue.
// ----------------------------------------------------------------------------
module tes_ctrl
    import tes_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  dp_stat_t stat,
    input  logic     out_free,
    output dp_ctl_t  ctl,
    output out_ctl_t oc
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        oc         = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    ctl.load   = 1'b1;
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                if (stat.is_tick)
                    state_next = ST_SCAN;
                else
                begin
                    ctl.apply  = 1'b1;
                    state_next = ST_REPLY;
                end
            end
            ST_REPLY:
            begin
                if (out_free)
                begin
                    oc.emit    = 1'b1;
                    oc.last    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                ctl.scan_step = 1'b1;
                if (stat.scan_last)
                    state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                // the previous firing goes out only once we know if another follows
                if (!stat.have_prev)
                begin
                    if (stat.found)
                        state_next = ST_FIRE;
                    else if (out_free)
                    begin
                        oc.emit    = 1'b1;
                        oc.last    = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else if (out_free)
                begin
                    oc.emit  = 1'b1;
                    oc.fired = 1'b1;
                    if (stat.found && stat.fires_left)
                        state_next = ST_FIRE;
                    else
                    begin
                        oc.last    = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_FIRE:
            begin
                ctl.fire   = 1'b1;
                state_next = ST_SCAN;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
        oc.emit |-> out_free)
        else $error("result issued with output register occupied");

    a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> in_stall)
        else $error("input open while an item is in work");

    a_load_on_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.load |-> (in_valid && !in_stall))
        else $error("item latched without an input transfer");

endmodule

// ===== sv/timer_expiry_scheduler.sv =====
// ----------------------------------------------------------------------------
// timer_expiry_scheduler
// Sixteen timer slots; ticks fire expired slots, earliest deadline first.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) takes one command per transfer: insert,
//   restart, remove, or tick with the current time in now. Output channel
//   (out_valid/out_stall) returns results: one per non-tick command or
//   empty tick, otherwise one per firing with last on the final one.
//   One item is in work at a time; in_stall is high from the transfer until
//   its final result has been placed in the output register.
//   A non-tick command is latched, applied, then its result is issued.
//   A tick scans the slots one per cycle, fires the earliest expired slot
//   and scans again, at most MAX_FIRES firings per tick.
//   The next command is taken in the cycle its predecessor's final
//   result can first leave.
//   Stall: results wait in a single output register; while it is held the
//   sequencer pauses before issuing the next result, and no state is lost.
//   Reset: all slots inactive, internal pending count zero, output empty. No
//   clearing pass is needed; the block takes items right after reset.
// ----------------------------------------------------------------------------
module timer_expiry_scheduler
    import tes_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        command,
    input  logic [ID_W-1:0]   timer_id,
    input  logic [IVL_W-1:0]  interval,
    input  logic              mode,
    input  logic [TIME_W-1:0] now,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              fired,
    output logic [ID_W-1:0]   fired_id,
    output logic              last,
    output logic [CNT_W-1:0]  pending_count
);

    dp_ctl_t           ctl;
    dp_stat_t          stat;
    out_ctl_t          oc;
    logic              out_free;
    logic [SLOT_W-1:0] dp_fired_slot;
    logic [CNT_W-1:0]  dp_count;

    logic              out_valid_reg;
    logic              fired_reg;
    logic [ID_W-1:0]   fired_id_reg;
    logic              last_reg;
    logic [CNT_W-1:0]  count_reg;

    assign out_free = !out_valid_reg || !out_stall;

    tes_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .out_free (out_free),
        .ctl      (ctl),
        .oc       (oc)
    );

    tes_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .command       (command),
        .timer_id      (timer_id),
        .interval      (interval),
        .mode          (mode),
        .now           (now),
        .stat          (stat),
        .fired_slot    (dp_fired_slot),
        .pending_count (dp_count)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (oc.emit)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (oc.emit)
        begin
            fired_reg    <= oc.fired;
            fired_id_reg <= oc.fired ? ID_W'(dp_fired_slot) : '0;
            last_reg     <= oc.last;
            count_reg    <= dp_count;
        end
    end

    assign out_valid     = out_valid_reg;
    assign fired         = fired_reg;
    assign fired_id      = fired_id_reg;
    assign last          = last_reg;
    assign pending_count = count_reg;

endmodule
